FILE: hw/rtl/amo_pkg.sv
// shared types and constants of the atomic memory operation unit
package amo_pkg;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int XLEN = 64;
   localparam int REQ_DATA_W = 200;
   localparam int RSP_DATA_W = 136;

   typedef enum logic [3:0] {
      OP_LR   = 4'd0,
      OP_SC   = 4'd1,
      OP_SWAP = 4'd2,
      OP_ADD  = 4'd3,
      OP_XOR  = 4'd4,
      OP_AND  = 4'd5,
      OP_OR   = 4'd6,
      OP_MIN  = 4'd7,
      OP_MAX  = 4'd8,
      OP_MINU = 4'd9,
      OP_MAXU = 4'd10
   } amo_op_type;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_FAULT   = 3'd1,
      KIND_LR      = 3'd2,
      KIND_SC_FAIL = 3'd3,
      KIND_SC_PASS = 3'd4,
      KIND_AMO     = 3'd5
   } amo_kind_type;

   typedef struct packed {
      amo_kind_type     kind;
      logic [3:0]       op;
      logic             is_word;
      logic [XLEN-1:0]  operand;
      logic [XLEN-1:0]  mem_old;
   } amo_entry_type;

   // packed so that rd_write lands in bit 0
   typedef struct packed {
      logic             fault;
      logic [XLEN-1:0]  store_data;
      logic             store_en;
      logic [XLEN-1:0]  rd_value;
      logic             rd_write;
   } amo_result_type;

   function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

endpackage

FILE: hw/rtl/amo_front.sv
// front end: accepts beats, classifies them and keeps the load reservation
module amo_front
   import amo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  q_full,
   output logic                  push,
   output amo_entry_type         entry
);

   logic            is_word;
   logic [XLEN-1:0] address;
   logic            mem_fault;
   logic            resv_match;

   logic            resv_valid_ff, resv_valid_in;
   logic [XLEN-1:0] resv_addr_ff, resv_addr_in;
   logic            resv_is_word_ff, resv_is_word_in;

   assign is_word   = req_tdata[0];
   assign address   = req_tdata[64:1];
   assign mem_fault = req_tdata[193];

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   assign resv_match = resv_valid_ff && (resv_addr_ff == address) &&
                       (resv_is_word_ff == is_word);

   always_comb begin
      entry.op      = req_tuser;
      entry.is_word = is_word;
      entry.operand = req_tdata[128:65];
      entry.mem_old = req_tdata[192:129];
      entry.kind    = KIND_NONE;
      resv_valid_in   = resv_valid_ff;
      resv_addr_in    = resv_addr_ff;
      resv_is_word_in = resv_is_word_ff;
      if (req_tuser == OP_LR) begin
         if (mem_fault) begin
            entry.kind = KIND_FAULT;
         end else begin
            entry.kind      = KIND_LR;
            resv_valid_in   = 1'b1;
            resv_addr_in    = address;
            resv_is_word_in = is_word;
         end
      end else if (req_tuser == OP_SC) begin
         if (!resv_match) begin
            entry.kind    = KIND_SC_FAIL;
            resv_valid_in = 1'b0;
         end else if (mem_fault) begin
            entry.kind = KIND_FAULT;
         end else begin
            entry.kind    = KIND_SC_PASS;
            resv_valid_in = 1'b0;
         end
      end else if (req_tuser inside {[OP_SWAP:OP_MAXU]}) begin
         entry.kind = mem_fault ? KIND_FAULT : KIND_AMO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resv_valid_ff   <= 1'b0;
         resv_addr_ff    <= '0;
         resv_is_word_ff <= 1'b0;
      end else if (push) begin
         resv_valid_ff   <= resv_valid_in;
         resv_addr_ff    <= resv_addr_in;
         resv_is_word_ff <= resv_is_word_in;
      end
   end

   lr_sets_resv: assert property (@(posedge clock) disable iff (reset)
      push && entry.kind == KIND_LR |=> resv_valid_ff)
      else $error("reservation not set after lr");

   sc_clears_resv: assert property (@(posedge clock) disable iff (reset)
      push && (entry.kind == KIND_SC_PASS || entry.kind == KIND_SC_FAIL) |=> !resv_valid_ff)
      else $error("reservation survived sc");

endmodule

FILE: hw/rtl/amo_queue.sv
// short queue between the front and back ends
module amo_queue
   import amo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  amo_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output amo_entry_type head
);

   amo_entry_type     mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

FILE: hw/rtl/amo_back.sv
// back end: executes the operation and holds the result beat
module amo_back
   import amo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  amo_entry_type         head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic            rsp_valid_ff;
   amo_result_type  rsp_ff, rsp_in;
   logic [XLEN-1:0] src, old, nv;
   logic            s_lt, s_gt, u_lt, u_gt;

   assign pop = head_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      src  = head.is_word ? sext32(head.operand) : head.operand;
      old  = head.is_word ? sext32(head.mem_old) : head.mem_old;
      s_lt = $signed(src) < $signed(old);
      s_gt = $signed(old) < $signed(src);
      u_lt = head.is_word ? (src[31:0] < old[31:0]) : (src < old);
      u_gt = head.is_word ? (old[31:0] < src[31:0]) : (old < src);
      case (head.op)
         OP_SWAP: nv = src;
         OP_ADD:  nv = old + src;
         OP_XOR:  nv = old ^ src;
         OP_AND:  nv = old & src;
         OP_OR:   nv = old | src;
         OP_MIN:  nv = s_lt ? src : old;
         OP_MAX:  nv = s_gt ? src : old;
         OP_MINU: nv = u_lt ? src : old;
         OP_MAXU: nv = u_gt ? src : old;
         default: nv = src;
      endcase
   end

   always_comb begin
      rsp_in = '0;
      case (head.kind)
         KIND_FAULT: rsp_in.fault = 1'b1;
         KIND_LR: begin
            rsp_in.rd_write = 1'b1;
            rsp_in.rd_value = old;
         end
         KIND_SC_FAIL: begin
            rsp_in.rd_write = 1'b1;
            rsp_in.rd_value = XLEN'(1);
         end
         KIND_SC_PASS: begin
            rsp_in.rd_write   = 1'b1;
            rsp_in.store_en   = 1'b1;
            rsp_in.store_data = src;
         end
         KIND_AMO: begin
            rsp_in.rd_write   = 1'b1;
            rsp_in.rd_value   = old;
            rsp_in.store_en   = 1'b1;
            rsp_in.store_data = nv;
         end
         default: rsp_in = '0;
      endcase
      if (head.is_word) begin
         rsp_in.store_data[63:32] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(amo_result_type)){1'b0}}, rsp_ff};

   fault_blocks_writes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fault |-> !rsp_ff.rd_write && !rsp_ff.store_en)
      else $error("faulted beat writes state");

   store_needs_rd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.store_en |-> rsp_ff.rd_write)
      else $error("store without register write");

endmodule

FILE: hw/rtl/atomic_memory_op_unit.sv
// top level of the atomic memory operation unit
//
// Executes LR, SC and AMO instructions of the RISC-V A extension at word or
// doubleword width. The req_ channel carries one instruction per beat: the
// operation code in req_tuser, and in req_tdata the width flag, address,
// register operand, old memory value and access fault flag. The rsp_ channel
// returns one beat per instruction: register write enable and value, store
// enable and data, and the fault flag.
// A beat is accepted whenever the queue has room; the front end decides the
// reservation outcome then, so instructions act on the reservation in order.
// The result beat is loaded onto rsp_ at the edge that takes the queue head;
// a beat passes through a queue entry and then the output register. Throughput
// is one beat per cycle while the receiver takes each result beat, set by the
// combinational ALU in the back end.
// When the receiver stalls, the result register holds its beat and the
// two-entry queue keeps taking beats until it fills; req_tready then falls.
// Reset clears the reservation, the queue and the output valid flag.
module atomic_memory_op_unit
   import amo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_type
   input  logic [3:0]            req_tuser,
   // is_word, address, operand, mem_old, mem_fault, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rd_write, rd_value, store_en, store_data, fault, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic          push;
   logic          full;
   logic          pop;
   logic          head_valid;
   amo_entry_type push_entry;
   amo_entry_type head;

   amo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (full),
      .push       (push),
      .entry      (push_entry)
   );

   amo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   amo_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
